// ===== hdl/pie_pkg.sv =====
// Package for the positional insert/extract list: sizes, action and status codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package pie_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int POS_W  = 16;
  localparam int ACT_W  = 3;
  localparam int ST_W   = 2;

  localparam int IN_TDATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_TDATA_W - VAL_W - POS_W;
  localparam int OUT_TDATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VAL_W - CNT_W;
  localparam int OUT_TUSER_W = ST_W;
  localparam int IN_TUSER_W  = ACT_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_INSERT     = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_POP_BACK   = 3'd4,
    ACT_EXTRACT    = 3'd5,
    ACT_READ       = 3'd6,
    ACT_WRITE      = 3'd7
  } act_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } st_t;

  // Where the target index of an item comes from.
  typedef enum logic [1:0] {
    IDX_FRONT = 2'd0,   // index 0
    IDX_BACK  = 2'd1,   // one past the last word
    IDX_LAST  = 2'd2,   // the last word
    IDX_POS   = 2'd3    // the item's position
  } idx_sel_t;

  typedef struct packed {
    logic     load;        // capture the item and its target index
    idx_sel_t idx_sel;
    logic     ptr_last;    // walk pointer starts at the last word, else at the index
    logic     zero_word;   // the word to place is zero
    logic     rd;          // read at the walk pointer and step it
    logic     shift_back;  // walk downwards, moved words go one place back
    logic     mv;          // write the word read last cycle to its neighbour
    logic     wr_word;     // write the item's word at the target index
    logic     cap_res;     // take the word read last cycle as the result
    logic     cnt_inc;
    logic     cnt_dec;
    logic     out_load;    // load the output register
    st_t      status;
  } pie_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_neg;      // item position below zero
    logic pos_past;     // item position at or beyond the count
    logic ptr_at_idx;   // walk pointer sits on the target index
    logic ptr_at_last;  // walk pointer sits on the last word
  } pie_stat_t;

endpackage

// ===== hdl/positional_insert_extract_list_top.sv =====
// Top level of the positional insert/extract list: stream ports, field packing
// and the controller/datapath pair. Depends on pie_pkg, pie_ctrl and pie_dpath.
//
// A bounded ordered list of up to 256 32-bit words, index 0 at the front.
// Each input item carries an action in in_tuser (push front/back, insert at a
// position, pop front/back, extract at a position, read, write) and returns
// exactly one result item with the extracted or read word, the count after the
// item and a status (ok, full and dropped, empty). Items are handled one at a
// time; the words live in a single-port-write, single-port-read memory, so a
// shift of n words walks through the memory one word a cycle. A push front, insert
// or append at the front first moves the words from the target index to the end
// one place back; an extract moves the words behind the removed one one place
// forward. The controller goes back to idle before the next item is taken. The
// output register lets the next item be accepted while the previous result still
// waits on out_tready. There is no clearing pass: words are only ever read below
// the fill count.
module positional_insert_extract_list_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input item
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] value, [47:32] position
  input  logic [pie_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] action
  input  logic [pie_pkg::IN_TUSER_W-1:0]  in_tuser,
  // result item
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] result_value, [40:32] element_count, [47:41] zero
  output logic [pie_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [pie_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import pie_pkg::*;

  pie_cmd_t          cmd;
  pie_stat_t         stat;
  logic [VAL_W-1:0]  in_value;
  logic [POS_W-1:0]  in_position;
  logic [VAL_W-1:0]  out_result;
  logic [CNT_W-1:0]  out_count;
  logic [ST_W-1:0]   out_status;

  // Unpack the input item; the pad bits of tdata carry nothing.
  assign in_value    = in_tdata[VAL_W-1:0];
  assign in_position = in_tdata[VAL_W+POS_W-1:VAL_W];

  pie_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_action  (in_tuser[ACT_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pie_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_value    (in_value),
    .in_position (in_position),
    .stat        (stat),
    .out_result  (out_result),
    .out_count   (out_count),
    .out_status  (out_status)
  );

  // Pack the result item, lowest field first, zero fill to whole bytes.
  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_count, out_result};
  assign out_tuser = out_status;

endmodule

// ===== hdl/pie_dpath.sv =====
// Datapath of the positional list: element memory, fill count, walk pointer,
// shift pipeline and output payload register. Depends on pie_pkg.
module pie_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pie_pkg::pie_cmd_t         cmd,
  input  logic [pie_pkg::VAL_W-1:0] in_value,
  input  logic [pie_pkg::POS_W-1:0] in_position,
  output pie_pkg::pie_stat_t        stat,
  output logic [pie_pkg::VAL_W-1:0] out_result,
  output logic [pie_pkg::CNT_W-1:0] out_count,
  output logic [pie_pkg::ST_W-1:0]  out_status
);
  import pie_pkg::*;

  logic [VAL_W-1:0]  mem [DEPTH];

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] idx_r, ptr_r, rd_addr_r;
  logic [VAL_W-1:0]  word_r, rd_data_r, res_r;
  logic              rd_vld_r;
  logic [VAL_W-1:0]  out_result_r;
  logic [CNT_W-1:0]  out_count_r;
  logic [ST_W-1:0]   out_status_r;

  logic [ADDR_W-1:0] idx_val, last_addr, wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic              wr_en;
  logic [POS_W-2:0]  cnt_ext;

  assign last_addr = ADDR_W'(cnt_r - CNT_W'(1));
  assign cnt_ext   = (POS_W-1)'(cnt_r);

  always_comb begin
    unique case (cmd.idx_sel)
      IDX_FRONT: idx_val = '0;
      IDX_BACK:  idx_val = cnt_r[ADDR_W-1:0];
      IDX_LAST:  idx_val = last_addr;
      IDX_POS:   idx_val = in_position[ADDR_W-1:0];
      default:   idx_val = '0;
    endcase
  end

  assign stat.full        = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty       = (cnt_r == '0);
  assign stat.pos_neg     = in_position[POS_W-1];
  assign stat.pos_past    = !in_position[POS_W-1] && (in_position[POS_W-2:0] >= cnt_ext);
  assign stat.ptr_at_idx  = (ptr_r == idx_r);
  assign stat.ptr_at_last = (ptr_r == last_addr);

  // Single write port: either a moved word or the item's own word.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = word_r;
    if (cmd.wr_word) begin
      wr_en = 1'b1;
    end else if (cmd.mv && rd_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = cmd.shift_back ? rd_addr_r + ADDR_W'(1) : rd_addr_r - ADDR_W'(1);
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rd_vld_r <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r  <= idx_val;
      word_r <= cmd.zero_word ? '0 : in_value;
      ptr_r  <= cmd.ptr_last ? last_addr : idx_val;
      res_r  <= '0;
    end else begin
      if (cmd.rd) begin
        ptr_r <= cmd.shift_back ? ptr_r - ADDR_W'(1) : ptr_r + ADDR_W'(1);
      end
      if (cmd.cap_res) begin
        res_r <= rd_data_r;
      end
    end
    if (cmd.rd) begin
      rd_addr_r <= ptr_r;
    end
    if (cmd.out_load) begin
      out_result_r <= res_r;
      out_count_r  <= cnt_r;
      out_status_r <= cmd.status;
    end
  end

  assign out_result = out_result_r;
  assign out_count  = out_count_r;
  assign out_status = out_status_r;

endmodule

// ===== hdl/pie_ctrl.sv =====
// Controller of the positional list: decodes each item and sequences the
// datapath through its shift walk. Depends on pie_pkg.
module pie_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [pie_pkg::ACT_W-1:0] in_action,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  pie_pkg::pie_stat_t        stat,
  output pie_pkg::pie_cmd_t         cmd
);
  import pie_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_UP_RD    = 13'b0000000000010,
    S_UP_TAIL  = 13'b0000000000100,
    S_PUT      = 13'b0000000001000,
    S_TK_FIRST = 13'b0000000010000,
    S_TK_CAP   = 13'b0000000100000,
    S_TK_MV    = 13'b0000001000000,
    S_TK_TAIL  = 13'b0000010000000,
    S_TK_LAST  = 13'b0000100000000,
    S_RD_ISSUE = 13'b0001000000000,
    S_RD_CAP   = 13'b0010000000000,
    S_WR_DO    = 13'b0100000000000,
    S_FIN      = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  st_t    st_r, st_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   in_range;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign in_range   = !stat.pos_neg && !stat.pos_past;

  always_comb begin
    cmd        = '0;
    cmd.status = st_r;
    state_nxt  = state_r;
    st_nxt     = st_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          st_nxt   = ST_OK;
          unique case (act_t'(in_action))
            ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT: begin
              if (stat.full) begin
                st_nxt    = ST_FULL;
                state_nxt = S_FIN;
              end else if (act_t'(in_action) == ACT_PUSH_FRONT ||
                           (act_t'(in_action) == ACT_INSERT && stat.pos_neg)) begin
                cmd.idx_sel  = IDX_FRONT;
                cmd.ptr_last = 1'b1;
                state_nxt    = stat.empty ? S_PUT : S_UP_RD;
              end else if (act_t'(in_action) == ACT_PUSH_BACK || stat.pos_past) begin
                cmd.idx_sel = IDX_BACK;
                state_nxt   = S_PUT;
              end else begin
                cmd.idx_sel  = IDX_POS;
                cmd.ptr_last = 1'b1;
                state_nxt    = S_UP_RD;
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK, ACT_EXTRACT: begin
              if (stat.empty) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_FIN;
              end else begin
                if (act_t'(in_action) == ACT_POP_FRONT ||
                    (act_t'(in_action) == ACT_EXTRACT && stat.pos_neg)) begin
                  cmd.idx_sel = IDX_FRONT;
                end else if (act_t'(in_action) == ACT_POP_BACK || stat.pos_past) begin
                  cmd.idx_sel = IDX_LAST;
                end else begin
                  cmd.idx_sel = IDX_POS;
                end
                state_nxt = S_TK_FIRST;
              end
            end
            ACT_READ, ACT_WRITE: begin
              cmd.zero_word = (act_t'(in_action) == ACT_READ);
              if (in_range) begin
                cmd.idx_sel = IDX_POS;
                state_nxt   = (act_t'(in_action) == ACT_READ) ? S_RD_ISSUE : S_WR_DO;
              end else if (stat.full) begin
                st_nxt    = ST_FULL;
                state_nxt = S_FIN;
              end else if (stat.pos_neg) begin
                cmd.idx_sel  = IDX_FRONT;
                cmd.ptr_last = 1'b1;
                state_nxt    = stat.empty ? S_PUT : S_UP_RD;
              end else begin
                cmd.idx_sel = IDX_BACK;
                state_nxt   = S_PUT;
              end
            end
          endcase
        end
      end
      S_UP_RD: begin
        cmd.rd         = 1'b1;
        cmd.mv         = 1'b1;
        cmd.shift_back = 1'b1;
        if (stat.ptr_at_idx) begin
          state_nxt = S_UP_TAIL;
        end
      end
      S_UP_TAIL: begin
        cmd.mv         = 1'b1;
        cmd.shift_back = 1'b1;
        state_nxt      = S_PUT;
      end
      S_PUT: begin
        cmd.wr_word = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_FIN;
      end
      S_TK_FIRST: begin
        cmd.rd    = 1'b1;
        state_nxt = stat.ptr_at_last ? S_TK_LAST : S_TK_CAP;
      end
      S_TK_CAP: begin
        cmd.cap_res = 1'b1;
        cmd.rd      = 1'b1;
        state_nxt   = stat.ptr_at_last ? S_TK_TAIL : S_TK_MV;
      end
      S_TK_MV: begin
        cmd.rd = 1'b1;
        cmd.mv = 1'b1;
        if (stat.ptr_at_last) begin
          state_nxt = S_TK_TAIL;
        end
      end
      S_TK_TAIL: begin
        cmd.mv      = 1'b1;
        cmd.cnt_dec = 1'b1;
        state_nxt   = S_FIN;
      end
      S_TK_LAST: begin
        cmd.cap_res = 1'b1;
        cmd.cnt_dec = 1'b1;
        state_nxt   = S_FIN;
      end
      S_RD_ISSUE: begin
        cmd.rd    = 1'b1;
        state_nxt = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd.cap_res = 1'b1;
        state_nxt   = S_FIN;
      end
      S_WR_DO: begin
        cmd.wr_word = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (!out_vld_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      st_r      <= ST_OK;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      st_r      <= st_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule
